/* rtl/touch_packet_deframe_and_scale_core_defines.svh */
// ----------------------------------------------------------------------------
// Touch packet deframer assertion macros
// Shared assertion shorthands for the touch packet deframe and scale core.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PACKET_DEFRAME_AND_SCALE_CORE_DEFINES_SVH
`define TOUCH_PACKET_DEFRAME_AND_SCALE_CORE_DEFINES_SVH

// Checks a property on the rising clock edge while reset is released.
`define TPDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpds assertion failed");

// Checks a property on the rising clock edge, including during reset.
`define TPDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpds assertion failed");

`endif

/* rtl/tpds_pkg.sv */
// ----------------------------------------------------------------------------
// Touch packet deframer package
// Shared widths, codes and types of the touch packet deframe and scale core.
// ----------------------------------------------------------------------------
package tpds_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ProdW     = 2 * CoordW;
  localparam int unsigned CountW    = 3;
  localparam int unsigned PktBytes  = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FracW     = 12;

  localparam logic [ByteW-1:0]  UntouchCode   = 8'h80;
  localparam logic [CoordW-1:0] WidthReset    = 16'd800;
  localparam logic [CoordW-1:0] HeightReset   = 16'd600;
  localparam logic [FracW:0]    FullScale     = 13'h0fff;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_WIDTH    = 2'd0,
    REG_SCREEN_HEIGHT   = 2'd1,
    REG_INVERT_X_ORIGIN = 2'd2,
    REG_INVERT_Y_ORIGIN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  command;
    logic [CoordW-1:0] raw_x;
    logic [CoordW-1:0] raw_y;
  } pkt_t;

endpackage

/* rtl/tpds_framer.sv */
// ----------------------------------------------------------------------------
// Touch packet framer
// Hunts for a start byte, gathers five-byte packets and holds each complete
// packet in a register until the scaling pipeline takes it.
// ----------------------------------------------------------------------------
module tpds_framer
  import tpds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             pop_i,
  output pkt_t             pkt_o
);

  localparam logic [CountW-1:0] LastCount = CountW'(PktBytes - 1);

  logic                  in_packet_q, in_packet_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [ByteW-1:0]      bytes_q [PktBytes-1];
  logic                  store_en;
  logic                  complete;
  logic                  pkt_valid_q, pkt_valid_d;
  logic [ByteW-1:0]      cmd_q;
  logic [CoordW-1:0]     raw_x_q, raw_y_q;

  always_comb begin
    in_packet_d = in_packet_q;
    count_d     = count_q;
    store_en    = 1'b0;
    complete    = 1'b0;
    if (accept_i) begin
      if (!in_packet_q) begin
        if (rx_byte_i[ByteW-1]) begin
          store_en    = 1'b1;
          in_packet_d = 1'b1;
          count_d     = CountW'(1);
        end else begin
          count_d = '0;
        end
      end else if (count_q >= LastCount) begin
        complete    = 1'b1;
        in_packet_d = 1'b0;
        count_d     = '0;
      end else begin
        store_en = 1'b1;
        count_d  = count_q + CountW'(1);
      end
    end
  end

  assign pkt_valid_d = (pkt_valid_q && !pop_i) || complete;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      count_q     <= '0;
      pkt_valid_q <= 1'b0;
    end else begin
      in_packet_q <= in_packet_d;
      count_q     <= count_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      bytes_q[count_d[1:0] - 2'd1] <= rx_byte_i;
    end
    if (complete) begin
      cmd_q   <= bytes_q[0];
      raw_y_q <= {bytes_q[1], bytes_q[2]};
      raw_x_q <= {bytes_q[3], rx_byte_i};
    end
  end

  assign pkt_o.valid   = pkt_valid_q;
  assign pkt_o.command = cmd_q;
  assign pkt_o.raw_x   = raw_x_q;
  assign pkt_o.raw_y   = raw_y_q;

endmodule

/* rtl/tpds_axis_scaler.sv */
// ----------------------------------------------------------------------------
// Touch axis scaler
// Multiplies a raw coordinate by the screen size, divides by full scale with
// a shift-and-fold reduction and applies the optional origin inversion.
// ----------------------------------------------------------------------------
module tpds_axis_scaler
  import tpds_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_prod_i,
  input  logic              load_out_i,
  input  logic [CoordW-1:0] raw_i,
  input  logic [CoordW-1:0] size_i,
  input  logic [CoordW-1:0] origin_i,
  output logic [CoordW-1:0] pos_o
);

  localparam int unsigned Q0W = ProdW - FracW;
  localparam int unsigned R0W = Q0W + 1;
  localparam int unsigned Q1W = R0W - FracW;
  localparam int unsigned R1W = FracW + 1;

  logic [ProdW-1:0]  prod_q;
  logic [Q0W-1:0]    q0;
  logic [R0W-1:0]    r0;
  logic [Q1W-1:0]    q1;
  logic [R1W-1:0]    r1;
  logic              carry;
  logic [CoordW-1:0] quot;
  logic [CoordW-1:0] pos_d;
  logic [CoordW-1:0] pos_q;

  // Division by 4095 uses p = 4096 * q + r, so p = 4095 * q + (q + r).
  always_comb begin
    q0    = prod_q[ProdW-1:FracW];
    r0    = R0W'(prod_q[FracW-1:0]) + R0W'(q0);
    q1    = r0[R0W-1:FracW];
    r1    = R1W'(r0[FracW-1:0]) + R1W'(q1);
    carry = (r1 >= FullScale);
    quot  = q0[CoordW-1:0] + CoordW'(q1) + CoordW'(carry);
    pos_d = (origin_i != '0) ? (origin_i - quot) : quot;
  end

  always_ff @(posedge clk_i) begin
    if (load_prod_i) begin
      prod_q <= size_i * raw_i;
    end
    if (load_out_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

/* rtl/touch_packet_deframe_and_scale_core.sv */
// ----------------------------------------------------------------------------
// Touch packet deframe and scale core
// Turns a serial byte stream from a touch controller into scaled positions.
// ----------------------------------------------------------------------------
// The core takes one received byte per clock cycle while the input is not
// stalled and gives one result per complete five-byte packet. A packet
// passes from the packet register through the product register of each axis
// multiplier to the output register.
// The input stalls only when all three registers are full and the output is
// stalled. Configuration writes are always taken in the cycle they are
// presented.
module touch_packet_deframe_and_scale_core
  import tpds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   command_o,
  output logic               pressed_o,
  output logic [CoordW-1:0]  pos_x_o,
  output logic [CoordW-1:0]  pos_y_o
);

`include "touch_packet_deframe_and_scale_core_defines.svh"

  logic [CoordW-1:0] width_q, height_q, x_origin_q, y_origin_q;
  pkt_t              pkt;
  logic              s1_ready, s1_adv;
  logic              s2_valid_q, s2_ready, s2_adv;
  logic              s3_valid_q, s3_ready;
  logic [ByteW-1:0]  cmd2_q, cmd3_q;
  logic              in_accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthReset;
      height_q   <= HeightReset;
      x_origin_q <= WidthReset;
      y_origin_q <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:    width_q    <= cfg_data_i;
        REG_SCREEN_HEIGHT:   height_q   <= cfg_data_i;
        REG_INVERT_X_ORIGIN: x_origin_q <= cfg_data_i;
        REG_INVERT_Y_ORIGIN: y_origin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s3_ready   = !s3_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && s3_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_adv     = pkt.valid && s2_ready;
  assign s1_ready   = !pkt.valid || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  tpds_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .pop_i     (s1_adv),
    .pkt_o     (pkt)
  );

  tpds_axis_scaler u_scale_x (
    .clk_i       (clk_i),
    .load_prod_i (s1_adv),
    .load_out_i  (s2_adv),
    .raw_i       (pkt.raw_x),
    .size_i      (width_q),
    .origin_i    (x_origin_q),
    .pos_o       (pos_x_o)
  );

  tpds_axis_scaler u_scale_y (
    .clk_i       (clk_i),
    .load_prod_i (s1_adv),
    .load_out_i  (s2_adv),
    .raw_i       (pkt.raw_y),
    .size_i      (height_q),
    .origin_i    (y_origin_q),
    .pos_o       (pos_y_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= pkt.valid;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      cmd2_q <= pkt.command;
    end
    if (s2_adv) begin
      cmd3_q <= cmd2_q;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign command_o   = cmd3_q;
  assign pressed_o   = (cmd3_q != UntouchCode);

  `TPDS_ASSERT(a_stall_needs_packet, clk_i, rst_ni, in_stall_o |-> pkt.valid)
  `TPDS_ASSERT(a_s1_moves_to_s2, clk_i, rst_ni, s1_adv |=> s2_valid_q)
  `TPDS_ASSERT(a_s2_held_on_stall, clk_i, rst_ni, (s2_valid_q && !s3_ready) |=> s2_valid_q)
  `TPDS_ASSERT(a_out_drains, clk_i, rst_ni,
               (out_valid_o && !out_stall_i && !s2_valid_q) |=> !out_valid_o)

endmodule
